@@ src/bmh_pkg.sv @@
package bmh_pkg;

    // command and status field widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // capacity register
    localparam int              CAP_W     = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

@@ src/bmh_if.sv @@
// command channel: one item is one heap operation
interface bmh_cmd_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [bmh_pkg::CMD_W-1:0]     cmd;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

// result channel: one item per command
interface bmh_rsp_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 9
);
    logic                          valid;
    logic                          ready;
    logic [bmh_pkg::STATUS_W-1:0]  status;
    logic signed [VALUE_WIDTH-1:0] removed_value;
    logic signed [VALUE_WIDTH-1:0] current_min;
    logic [COUNT_WIDTH-1:0]        entry_count;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, status, removed_value, current_min, entry_count,
                    is_empty, is_full, input ready);
    modport sink   (input valid, status, removed_value, current_min, entry_count,
                    is_empty, is_full, output ready);
endinterface

@@ src/bmh_ram.sv @@
module bmh_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic signed [DATA_W-1:0]          wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic signed [DATA_W-1:0]          rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bmh_engine.sv @@
module bmh_engine #(
    parameter int MAX_ENTRIES = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [bmh_pkg::CAP_W-1:0]              capacity,
    bmh_cmd_if.sink                                cmd_ch,
    bmh_rsp_if.source                              rsp_ch,
    output logic                                   mem_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]         mem_wr_addr,
    output logic signed [VALUE_WIDTH-1:0]          mem_wr_data,
    output logic                                   mem_rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]         mem_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0]          mem_rd_data
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int EW     = (CNT_W > bmh_pkg::CAP_W) ? CNT_W : bmh_pkg::CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_DEL_LAST,
        S_DEL_LEFT,
        S_DEL_RIGHT,
        S_PLACE,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic signed [VALUE_WIDTH-1:0] left_reg, left_next;
    logic signed [VALUE_WIDTH-1:0] root_reg, root_next;
    logic signed [VALUE_WIDTH-1:0] removed_reg, removed_next;
    bmh_pkg::status_t              status_reg, status_next;

    logic                          out_valid_reg, out_valid_next;
    bmh_pkg::status_t              out_status_reg, out_status_next;
    logic signed [VALUE_WIDTH-1:0] out_removed_reg, out_removed_next;
    logic signed [VALUE_WIDTH-1:0] out_min_reg, out_min_next;
    logic [CNT_W-1:0]              out_count_reg, out_count_next;
    logic                          out_empty_reg, out_empty_next;
    logic                          out_full_reg, out_full_next;

    logic                          accept;
    logic                          full_w;
    logic [EW-1:0]                 cap_ext;
    logic [EW-1:0]                 max_ext;
    logic [EW-1:0]                 eff_cap;
    logic [CNT_W:0]                child_w;
    logic [CNT_W:0]                n_w;
    logic                          pick_right;
    logic signed [VALUE_WIDTH-1:0] best_val;
    logic [CNT_W-1:0]              best_slot;
    logic [CNT_W:0]                grand_w;
    logic [CNT_W-1:0]              new_slot;
    logic [CNT_W-1:0]              up_slot;
    logic                          wr_en;
    logic [CNT_W-1:0]              wr_slot;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic                          rd_en;
    logic [CNT_W-1:0]              rd_slot;

    // heap slots count from one, the store from zero
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W-1:0] slot);
        logic [CNT_W-1:0] t;
        t = slot - CNT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    // effective capacity and full flag
    always_comb
    begin
        cap_ext = EW'(capacity);
        max_ext = EW'(MAX_ENTRIES);
        eff_cap = (cap_ext > max_ext) ? max_ext : cap_ext;
        full_w  = (EW'(cnt_reg) >= eff_cap);
    end

    // child selection for the down walk
    always_comb
    begin
        child_w    = {idx_reg, 1'b0};
        n_w        = {1'b0, cnt_reg};
        pick_right = (child_w < n_w) && (mem_rd_data < left_reg);
        best_val   = pick_right ? mem_rd_data : left_reg;
        best_slot  = child_w[CNT_W-1:0] | CNT_W'(pick_right);
        grand_w    = {best_slot, 1'b0};
        new_slot   = cnt_reg + CNT_W'(1);
        up_slot    = idx_reg >> 1;
    end

    assign accept = cmd_ch.valid && cmd_ch.ready;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        key_next         = key_reg;
        left_next        = left_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !rsp_ch.ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_min_next     = out_min_reg;
        out_count_next   = out_count_reg;
        out_empty_next   = out_empty_reg;
        out_full_next    = out_full_reg;
        wr_en            = 1'b0;
        wr_slot          = idx_reg;
        wr_data          = key_reg;
        rd_en            = 1'b0;
        rd_slot          = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = bmh_pkg::ST_DONE;
                    state_next   = S_DONE;
                    case (cmd_ch.cmd)
                        bmh_pkg::CMD_INSERT:
                        begin
                            if (full_w)
                            begin
                                status_next = bmh_pkg::ST_FULL;
                            end
                            else
                            begin
                                cnt_next = new_slot;
                                idx_next = new_slot;
                                key_next = cmd_ch.value;
                                if (cnt_reg == '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_slot = new_slot;
                                    wr_data = cmd_ch.value;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_slot    = new_slot >> 1;
                                    state_next = S_INS_CMP;
                                end
                            end
                        end
                        bmh_pkg::CMD_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = bmh_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                removed_next = root_reg;
                                cnt_next     = cnt_reg - CNT_W'(1);
                                rd_en        = 1'b1;
                                rd_slot      = cnt_reg;
                                state_next   = S_DEL_LAST;
                            end
                        end
                        bmh_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // parent arrived: move it down or place the key
            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (mem_rd_data > key_reg)
                begin
                    wr_data  = mem_rd_data;
                    idx_next = up_slot;
                    if (up_slot == CNT_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_slot = up_slot >> 1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // old last element arrived, start at the root
            S_DEL_LAST:
            begin
                key_next = mem_rd_data;
                idx_next = CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    wr_en      = 1'b1;
                    wr_slot    = CNT_W'(1);
                    wr_data    = mem_rd_data;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_slot    = CNT_W'(2);
                    state_next = S_DEL_LEFT;
                end
            end

            // left child arrived, fetch the right one if present
            S_DEL_LEFT:
            begin
                left_next  = mem_rd_data;
                state_next = S_DEL_RIGHT;
                if (child_w < n_w)
                begin
                    rd_en   = 1'b1;
                    rd_slot = child_w[CNT_W-1:0] + CNT_W'(1);
                end
            end

            // pull the smaller child up or settle the moving element
            S_DEL_RIGHT:
            begin
                wr_en = 1'b1;
                if (best_val < key_reg)
                begin
                    wr_data  = best_val;
                    idx_next = best_slot;
                    if (grand_w > n_w)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_slot    = grand_w[CNT_W-1:0];
                        state_next = S_DEL_LEFT;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ch.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_removed_next = removed_reg;
                    out_min_next     = (cnt_reg != '0) ? root_reg : '0;
                    out_count_next   = cnt_reg;
                    out_empty_next   = (cnt_reg == '0);
                    out_full_next    = full_w;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root copy follows every write of the first slot
    always_comb
    begin
        root_next = root_reg;
        if (wr_en && (wr_slot == CNT_W'(1)))
        begin
            root_next = wr_data;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        key_reg         <= key_next;
        left_reg        <= left_next;
        root_reg        <= root_next;
        removed_reg     <= removed_next;
        status_reg      <= status_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_min_reg     <= out_min_next;
        out_count_reg   <= out_count_next;
        out_empty_reg   <= out_empty_next;
        out_full_reg    <= out_full_next;
    end

    // store port
    assign mem_wr_en   = wr_en;
    assign mem_wr_addr = slot_addr(wr_slot);
    assign mem_wr_data = wr_data;
    assign mem_rd_en   = rd_en;
    assign mem_rd_addr = slot_addr(rd_slot);

    // channels
    assign cmd_ch.ready         = (state_reg == S_IDLE);
    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.status        = out_status_reg;
    assign rsp_ch.removed_value = out_removed_reg;
    assign rsp_ch.current_min   = out_min_reg;
    assign rsp_ch.entry_count   = out_count_reg;
    assign rsp_ch.is_empty      = out_empty_reg;
    assign rsp_ch.is_full       = out_full_reg;

endmodule

@@ src/binary_min_heap_unit.sv @@
// sequence from accept to result valid: clear, no-op and refused commands go straight to the result;
// insert compares with one parent per level the new value climbs (at most log2 depth), then places it;
// delete reads the old last element and is done there when at most one entry remains, else per level
// it reads the left child and then the right one, one at a time, as the last element sinks.
// throughput: one item at a time, the next accepted as the previous result waits.
// reset clears count, sequencer and result valid, capacity goes to 256; store is not cleared.
module binary_min_heap_unit #(
    parameter int MAX_ENTRIES = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bmh_pkg::CAP_W-1:0] cfg_wr_data,
    bmh_cmd_if.sink                   cmd_ch,
    bmh_rsp_if.source                 rsp_ch
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);

    logic [bmh_pkg::CAP_W-1:0]     capacity_reg;
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic signed [VALUE_WIDTH-1:0] mem_wr_data;
    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    logic signed [VALUE_WIDTH-1:0] mem_rd_data;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bmh_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    bmh_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .cmd_ch      (cmd_ch),
        .rsp_ch      (rsp_ch),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bmh_ram #(
        .DEPTH  (MAX_ENTRIES),
        .DATA_W (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

@@ src/bmh_checker.sv @@
module bmh_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 9
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [bmh_pkg::STATUS_W-1:0] status,
    input logic [VALUE_WIDTH-1:0]       removed_value,
    input logic [VALUE_WIDTH-1:0]       current_min,
    input logic [COUNT_WIDTH-1:0]       entry_count,
    input logic                         is_empty,
    input logic                         is_full
);

    // a waiting result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag and count disagree");

    // refused insert only when full and removes nothing
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bmh_pkg::ST_FULL) |-> is_full && (removed_value == '0))
        else $error("refused insert on a heap that is not full");

    // refused delete only when empty and removes nothing
    a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bmh_pkg::ST_EMPTY) |-> is_empty && (removed_value == '0))
        else $error("refused delete on a heap that is not empty");

    // an empty heap reports a zero minimum
    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> (current_min == '0))
        else $error("nonzero minimum on an empty heap");

endmodule

bind binary_min_heap_unit bmh_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH ($clog2(MAX_ENTRIES + 1))
) u_bmh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .status        (rsp_ch.status),
    .removed_value (rsp_ch.removed_value),
    .current_min   (rsp_ch.current_min),
    .entry_count   (rsp_ch.entry_count),
    .is_empty      (rsp_ch.is_empty),
    .is_full       (rsp_ch.is_full)
);

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 256;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 9;

    // receiver hold-off and no-idle window, start points counted in accepted items
    localparam int STALL_AT    = 1180;
    localparam int STALL_LEN   = 300;
    localparam int CALM_FROM   = 1250;
    localparam int CALM_TO     = 1400;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_LIMIT = 60;

    typedef struct {
        bmh_pkg::cmd_t             op;
        logic signed [VALUE_W-1:0] value;
    } heap_cmd_t;

    typedef struct {
        logic [bmh_pkg::STATUS_W-1:0] status;
        logic signed [VALUE_W-1:0]    removed_value;
        logic signed [VALUE_W-1:0]    current_min;
        logic [COUNT_W-1:0]           entry_count;
        logic                         is_empty;
        logic                         is_full;
    } heap_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [bmh_pkg::CAP_W-1:0] cfg_wr_data;

    bmh_cmd_if #(.VALUE_WIDTH(VALUE_W)) cmd_ch ();
    bmh_rsp_if #(.VALUE_WIDTH(VALUE_W), .COUNT_WIDTH(COUNT_W)) rsp_ch ();

    binary_min_heap_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_ch      (cmd_ch),
        .rsp_ch      (rsp_ch)
    );

    // predicted heap contents and settings
    logic signed [VALUE_W-1:0] model_slots [1:MAX_ENTRIES];
    int unsigned               model_fill;
    logic [bmh_pkg::CAP_W-1:0] model_capacity;

    heap_cmd_t    pending_cmds [$];
    heap_result_t heap_expect  [$];

    int  accepted_cmds;
    int  checked_results;
    int  mismatch_count;
    bit  cmd_taken;
    int  stall_left;
    bit  stall_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // heap operation as the block should perform it
    function automatic heap_result_t apply_heap_op(bmh_pkg::cmd_t op,
                                                   logic signed [VALUE_W-1:0] v);
        heap_result_t              r;
        int unsigned               room;
        int unsigned               i;
        int unsigned               c;
        int unsigned               n;
        bit                        sinking;
        logic signed [VALUE_W-1:0] last;

        room = (model_capacity > MAX_ENTRIES) ? MAX_ENTRIES : model_capacity;
        r.status        = bmh_pkg::ST_DONE;
        r.removed_value = '0;
        case (op)
            bmh_pkg::CMD_INSERT:
            begin
                if (model_fill >= room)
                    r.status = bmh_pkg::ST_FULL;
                else
                begin
                    // climb past strictly larger parents
                    model_fill++;
                    i = model_fill;
                    while (i > 1 && model_slots[i / 2] > v)
                    begin
                        model_slots[i] = model_slots[i / 2];
                        i = i / 2;
                    end
                    model_slots[i] = v;
                end
            end
            bmh_pkg::CMD_DELETE:
            begin
                if (model_fill == 0)
                    r.status = bmh_pkg::ST_EMPTY;
                else
                begin
                    // take the root, sink the last entry toward the smaller child
                    r.removed_value = model_slots[1];
                    last = model_slots[model_fill];
                    model_fill--;
                    n = model_fill;
                    i = 1;
                    sinking = 1'b1;
                    while (sinking && 2 * i <= n)
                    begin
                        c = 2 * i;
                        if (c < n && model_slots[c + 1] < model_slots[c])
                            c++;
                        if (model_slots[c] < last)
                        begin
                            model_slots[i] = model_slots[c];
                            i = c;
                        end
                        else
                            sinking = 1'b0;
                    end
                    if (n > 0)
                        model_slots[i] = last;
                end
            end
            bmh_pkg::CMD_CLEAR:
                model_fill = 0;
            default:
                ;
        endcase
        r.current_min = (model_fill > 0) ? model_slots[1] : '0;
        r.entry_count = model_fill[COUNT_W-1:0];
        r.is_empty    = (model_fill == 0);
        r.is_full     = (model_fill >= room);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // input values: extremes, a narrow band for equal keys, full random
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2, 3:    return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input bmh_pkg::cmd_t op, input logic signed [VALUE_W-1:0] v);
        heap_cmd_t item;
        item.op    = op;
        item.value = v;
        pending_cmds.push_back(item);
    endtask

    // random mix of operations, no-op takes the remaining share
    task automatic queue_ops(input int count, input int ins_pct, input int del_pct,
                             input int clr_pct);
        int            r;
        bmh_pkg::cmd_t op;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                op = bmh_pkg::CMD_INSERT;
            else if (r < ins_pct + del_pct)
                op = bmh_pkg::CMD_DELETE;
            else if (r < ins_pct + del_pct + clr_pct)
                op = bmh_pkg::CMD_CLEAR;
            else
                op = bmh_pkg::CMD_NOP;
            push_op(op, pick_value());
        end
    endtask

    // wait until every item is sent and every result is back
    task automatic settle();
        while (pending_cmds.size() != 0 || cmd_ch.valid || heap_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [bmh_pkg::CAP_W-1:0] cap);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        model_capacity = cap;
    endtask

    // known levels from time zero
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.cmd     = bmh_pkg::CMD_NOP;
        cmd_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        model_fill     = 0;
        model_capacity = bmh_pkg::CAP_RESET;
        mismatch_count = 0;
    end

    // command driver
    always @(negedge clk)
    begin : drive_cmd
        heap_cmd_t nxt;
        bit        calm;
        calm = (accepted_cmds >= CALM_FROM && accepted_cmds < CALM_TO);
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_taken)
        begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 22))
            begin
                nxt = pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.cmd   <= nxt.op;
                cmd_ch.value <= nxt.value;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result receiver with one long hold-off
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!stall_done && accepted_cmds >= STALL_AT)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= STALL_LEN;
            stall_done   <= 1'b1;
        end
        else
            rsp_ch.ready <= (accepted_cmds >= CALM_FROM && accepted_cmds < CALM_TO)
                            || ($urandom_range(0, 99) >= 22);
    end

    // accepted items feed the predictor
    always @(posedge clk)
    begin : take_cmd
        if (!rst_n)
        begin
            cmd_taken     <= 1'b0;
            accepted_cmds <= 0;
        end
        else
        begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                heap_expect.push_back(apply_heap_op(bmh_pkg::cmd_t'(cmd_ch.cmd),
                                                    cmd_ch.value));
                accepted_cmds <= accepted_cmds + 1;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        heap_result_t want;
        if (!rst_n)
            checked_results <= 0;
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (heap_expect.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          checked_results));
            else
            begin
                want = heap_expect.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("result %0d status %h, want %h",
                                              checked_results, rsp_ch.status, want.status));
                if (rsp_ch.removed_value !== want.removed_value)
                    report_mismatch($sformatf("result %0d removed_value %h, want %h",
                                              checked_results, rsp_ch.removed_value,
                                              want.removed_value));
                if (rsp_ch.current_min !== want.current_min)
                    report_mismatch($sformatf("result %0d current_min %h, want %h",
                                              checked_results, rsp_ch.current_min,
                                              want.current_min));
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                              checked_results, rsp_ch.entry_count,
                                              want.entry_count));
                if (rsp_ch.is_empty !== want.is_empty)
                    report_mismatch($sformatf("result %0d is_empty %b, want %b",
                                              checked_results, rsp_ch.is_empty,
                                              want.is_empty));
                if (rsp_ch.is_full !== want.is_full)
                    report_mismatch($sformatf("result %0d is_full %b, want %b",
                                              checked_results, rsp_ch.is_full,
                                              want.is_full));
            end
            checked_results <= checked_results + 1;
        end
    end

    // stimulus phases
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset capacity: empty delete, no-op, extremes, equal keys
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_NOP, -32'sd1);
        push_op(bmh_pkg::CMD_INSERT, 32'sh7fffffff);
        push_op(bmh_pkg::CMD_INSERT, 32'sh80000000);
        push_op(bmh_pkg::CMD_INSERT, 32'sd0);
        push_op(bmh_pkg::CMD_INSERT, -32'sd1);
        push_op(bmh_pkg::CMD_INSERT, 32'sd5);
        push_op(bmh_pkg::CMD_INSERT, 32'sd5);
        push_op(bmh_pkg::CMD_INSERT, 32'sd5);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);

        // capacity below the held count
        write_capacity(9'd3);
        push_op(bmh_pkg::CMD_INSERT, 32'sd1);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_INSERT, 32'sd9);
        push_op(bmh_pkg::CMD_INSERT, 32'sd2);
        push_op(bmh_pkg::CMD_CLEAR, 32'sd0);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);

        // zero capacity refuses every insert
        write_capacity(9'd0);
        push_op(bmh_pkg::CMD_INSERT, 32'sd4);
        push_op(bmh_pkg::CMD_NOP, 32'sd0);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);

        // capacity above the store depth
        write_capacity(9'd511);
        push_op(bmh_pkg::CMD_INSERT, 32'sh80000000);
        push_op(bmh_pkg::CMD_INSERT, 32'sh80000000);
        push_op(bmh_pkg::CMD_DELETE, 32'sd0);
        push_op(bmh_pkg::CMD_CLEAR, 32'sd0);

        // fill to the store depth, then drain past empty
        queue_ops(350, 85, 10, 0);
        queue_ops(300, 10, 85, 0);

        write_capacity(9'd1);
        queue_ops(80, 45, 45, 3);
        write_capacity(9'd2);
        queue_ops(80, 45, 45, 3);
        write_capacity(9'd17);
        queue_ops(300, 55, 40, 2);

        // full depth with hold-off and no-idle stretch
        write_capacity(9'd256);
        queue_ops(300, 60, 35, 1);

        // shrink below whatever is held
        write_capacity(9'($urandom_range(1, 20)));
        queue_ops(100, 40, 55, 0);

        write_capacity(9'd300);
        queue_ops(150, 55, 40, 2);
        write_capacity(9'd0);
        queue_ops(30, 50, 30, 5);

        for (int p = 0; p < 4; p++)
        begin
            write_capacity(9'($urandom_range(0, 511)));
            queue_ops(60, 50, 45, 2);
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && heap_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
src/bmh_pkg.sv
src/bmh_if.sv
src/bmh_ram.sv
src/bmh_engine.sv
src/binary_min_heap_unit.sv
src/bmh_checker.sv
bench/testbench.sv
